// ----- rtl/core/mrtu_pkg.sv -----
`default_nettype none
package mrtu_pkg;

  localparam int HOLDING_WORDS_DEF   = 256;
  localparam int INPUT_WORDS_DEF     = 512;
  localparam int MAX_WRITE_WORDS_DEF = 16;
  localparam int MAX_READ_WORDS_DEF  = 29;
  localparam int RX_BYTES_DEF        = 64;

  // Item kinds on in_tuser.
  localparam logic [1:0] OP_FRAME     = 2'd0;
  localparam logic [1:0] OP_LOAD_IN   = 2'd1;
  localparam logic [1:0] OP_LOAD_HOLD = 2'd2;

  // Result kinds on out_tuser.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_ADDR = 1'b0;
  localparam logic CFG_PROT_LIMIT = 1'b1;

  // Function codes.
  localparam logic [7:0] FC_READ_HOLD  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT = 8'd4;
  localparam logic [7:0] FC_WRITE_ONE  = 8'd6;
  localparam logic [7:0] FC_WRITE_MANY = 8'd16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       init;
    logic       load;
    logic [7:0] data;
  } crc_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/modbus_rtu_slave_register_engine.sv -----
// Store-load words are written into their store as they are accepted. For a frame byte
// the running CRC is folded in one bit per cycle by the serial CRC unit.
// At frame end: a check step, then the states S_WR_A, S_WR_B and S_WR_C for each written
// word of a multiple write, then each response byte is loaded and its CRC folded serially,
// with S_RD_ADDR and S_RD_DATA before the high byte of each read word, plus output stalls.
// Reset is synchronous, active low; afterwards a clearing pass over max(HOLDING_WORDS,
// INPUT_WORDS) addresses zeroes both stores before the first word is accepted.
`default_nettype none
module modbus_rtu_slave_register_engine
  import mrtu_pkg::*;
#(
  parameter int HOLDING_WORDS   = HOLDING_WORDS_DEF,
  parameter int INPUT_WORDS     = INPUT_WORDS_DEF,
  parameter int MAX_WRITE_WORDS = MAX_WRITE_WORDS_DEF,
  parameter int MAX_READ_WORDS  = MAX_READ_WORDS_DEF,
  parameter int RX_BYTES        = RX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // frame_byte, reg_index, reg_value, zero fill
  input  wire logic [1:0]  in_tuser,   // opcode
  input  wire logic        in_tlast,   // end_of_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // out_byte
  output logic             out_tuser,  // out_kind
  output logic             out_tlast,  // last_of_response
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int HA_W      = $clog2(HOLDING_WORDS);
  localparam int IA_W      = $clog2(INPUT_WORDS);
  localparam int RXA_W     = $clog2(RX_BYTES);
  localparam int LEN_W     = $clog2(RX_BYTES + 1);
  localparam int CLR_DEPTH = (HOLDING_WORDS > INPUT_WORDS) ? HOLDING_WORDS : INPUT_WORDS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int MAX_WORDS = (MAX_READ_WORDS > MAX_WRITE_WORDS) ?
                             MAX_READ_WORDS : MAX_WRITE_WORDS;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'h0001,
    S_IDLE    = 15'h0002,
    S_RXCRC   = 15'h0004,
    S_CHECK   = 15'h0008,
    S_WR_A    = 15'h0010,
    S_WR_B    = 15'h0020,
    S_WR_C    = 15'h0040,
    S_TX_NEXT = 15'h0080,
    S_RD_ADDR = 15'h0100,
    S_RD_DATA = 15'h0200,
    S_TX_LOAD = 15'h0400,
    S_TX_CRC  = 15'h0800,
    S_CRC_LO  = 15'h1000,
    S_CRC_HI  = 15'h2000,
    S_RESTART = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]       slave_addr_r, prot_limit_r;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic [LEN_W-1:0] rx_len_r, rx_len_nxt;
  logic             rx_ovf_r, rx_ovf_nxt;
  logic             eof_r, eof_nxt;
  logic [7:0]       hdr_addr_r, hdr_addr_nxt, hdr_fc_r, hdr_fc_nxt, bc_r, bc_nxt;
  logic [15:0]      ad_r, ad_nxt, wc_r, wc_nxt, cur_ad_r, cur_ad_nxt, word_r, word_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [RXA_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic             phase_r, phase_nxt, is_read_r, is_read_nxt, is_hold_r, is_hold_nxt;
  logic [7:0]       tx_byte_r, tx_byte_nxt;
  logic             out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;

  logic             hold_we, inp_we, rx_we;
  logic [HA_W-1:0]  hold_waddr;
  logic [IA_W-1:0]  inp_waddr;
  logic [15:0]      hold_wdata, inp_wdata, hold_rdata, inp_rdata;
  logic [7:0]       rx_rdata;
  crc_ctl_t         crc_ctl;
  logic [15:0]      crc;
  logic             crc_busy;

  logic             in_accept, out_free;
  logic [7:0]       in_byte;
  logic [8:0]       in_idx;
  logic [15:0]      in_val;
  logic [16:0]      ad_end;
  logic [9:0]       len10;
  logic             hdr_ok, rd_ok, wm_ok, crc_good;

  assign in_byte   = in_tdata[7:0];
  assign in_idx    = in_tdata[16:8];
  assign in_val    = in_tdata[32:17];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ad_end   = {1'b0, ad_r} + {1'b0, wc_r};
  assign len10    = 10'(rx_len_r);
  // A frame that carries its own correct CRC leaves a zero residue.
  assign crc_good = (crc == 16'd0);
  assign hdr_ok   = (len10 >= 10'd2) && (hdr_addr_r == slave_addr_r);
  assign rd_ok    = (wc_r != 16'd0) && (wc_r <= 16'(MAX_READ_WORDS)) &&
                    (ad_end <= ((hdr_fc_r == FC_READ_HOLD) ? 17'(HOLDING_WORDS)
                                                           : 17'(INPUT_WORDS)));
  assign wm_ok    = (len10 >= 10'd9) && (len10 == 10'd9 + {2'd0, bc_r}) && crc_good &&
                    (wc_r != 16'd0) && (wc_r <= 16'(MAX_WRITE_WORDS)) &&
                    ({9'd0, bc_r} == {wc_r, 1'b0}) && (ad_end <= 17'(HOLDING_WORDS));

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    rx_len_nxt   = rx_len_r;
    rx_ovf_nxt   = rx_ovf_r;
    eof_nxt      = eof_r;
    hdr_addr_nxt = hdr_addr_r;
    hdr_fc_nxt   = hdr_fc_r;
    bc_nxt       = bc_r;
    ad_nxt       = ad_r;
    wc_nxt       = wc_r;
    cur_ad_nxt   = cur_ad_r;
    word_nxt     = word_r;
    left_nxt     = left_r;
    wr_idx_nxt   = wr_idx_r;
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    is_read_nxt  = is_read_r;
    is_hold_nxt  = is_hold_r;
    tx_byte_nxt  = tx_byte_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    hold_we      = 1'b0;
    hold_waddr   = cur_ad_r[HA_W-1:0];
    hold_wdata   = 16'd0;
    inp_we       = 1'b0;
    inp_waddr    = IA_W'(in_idx);
    inp_wdata    = in_val;
    rx_we        = 1'b0;
    crc_ctl      = '0;

    unique case (state_r)
      S_CLEAR: begin
        hold_we    = (32'(clr_r) < HOLDING_WORDS);
        hold_waddr = HA_W'(clr_r);
        inp_we     = (32'(clr_r) < INPUT_WORDS);
        inp_waddr  = IA_W'(clr_r);
        inp_wdata  = 16'd0;
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + CLR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_tuser)
            OP_FRAME: begin
              if (32'(rx_len_r) < RX_BYTES) begin
                rx_we        = 1'b1;
                crc_ctl.init = (rx_len_r == '0);
                crc_ctl.load = 1'b1;
                crc_ctl.data = in_byte;
                unique case (rx_len_r)
                  LEN_W'(0): hdr_addr_nxt = in_byte;
                  LEN_W'(1): hdr_fc_nxt   = in_byte;
                  LEN_W'(2): ad_nxt[15:8] = in_byte;
                  LEN_W'(3): ad_nxt[7:0]  = in_byte;
                  LEN_W'(4): wc_nxt[15:8] = in_byte;
                  LEN_W'(5): wc_nxt[7:0]  = in_byte;
                  LEN_W'(6): bc_nxt       = in_byte;
                  default: ;
                endcase
                rx_len_nxt = rx_len_r + LEN_W'(1);
                eof_nxt    = in_tlast;
                state_nxt  = S_RXCRC;
              end else if (in_tlast) begin
                rx_len_nxt = '0;
                rx_ovf_nxt = 1'b0;
              end else begin
                rx_ovf_nxt = 1'b1;
              end
            end
            OP_LOAD_IN: begin
              inp_we = (32'(in_idx) < INPUT_WORDS);
            end
            OP_LOAD_HOLD: begin
              hold_we    = (32'(in_idx) < HOLDING_WORDS);
              hold_waddr = HA_W'(in_idx);
              hold_wdata = in_val;
            end
            default: ;
          endcase
        end
      end
      S_RXCRC: begin
        if (!crc_busy) begin
          state_nxt = eof_r ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        rx_len_nxt   = '0;
        rx_ovf_nxt   = 1'b0;
        state_nxt    = S_IDLE;
        cur_ad_nxt   = ad_r;
        left_nxt     = CNT_W'(wc_r);
        wr_idx_nxt   = RXA_W'(7);
        pos_nxt      = 3'd0;
        phase_nxt    = 1'b0;
        is_hold_nxt  = (hdr_fc_r == FC_READ_HOLD);
        crc_ctl.init = 1'b1;
        if (hdr_ok) begin
          priority if ((hdr_fc_r == FC_WRITE_ONE) && (len10 == 10'd8) && crc_good) begin
            if (ad_r < 16'(HOLDING_WORDS)) begin
              if (ad_r > {8'd0, prot_limit_r}) begin
                hold_we     = 1'b1;
                hold_waddr  = ad_r[HA_W-1:0];
                hold_wdata  = wc_r;
                is_read_nxt = 1'b0;
                state_nxt   = S_TX_NEXT;
              end else begin
                state_nxt = S_RESTART;
              end
            end
          end else if (((hdr_fc_r == FC_READ_HOLD) || (hdr_fc_r == FC_READ_INPUT)) &&
                       (len10 == 10'd8) && crc_good) begin
            if (rd_ok) begin
              is_read_nxt = 1'b1;
              state_nxt   = S_TX_NEXT;
            end
          end else if ((hdr_fc_r == FC_WRITE_MANY) && wm_ok) begin
            is_read_nxt = 1'b0;
            state_nxt   = S_WR_A;
          end
        end
      end
      S_WR_A: begin
        wr_idx_nxt = wr_idx_r + RXA_W'(1);
        state_nxt  = S_WR_B;
      end
      S_WR_B: begin
        word_nxt[15:8] = rx_rdata;
        wr_idx_nxt     = wr_idx_r + RXA_W'(1);
        state_nxt      = S_WR_C;
      end
      S_WR_C: begin
        // Protected words inside a multiple write are skipped.
        hold_we    = (cur_ad_r > {8'd0, prot_limit_r});
        hold_wdata = {word_r[15:8], rx_rdata};
        cur_ad_nxt = cur_ad_r + 16'd1;
        left_nxt   = left_r - CNT_W'(1);
        state_nxt  = (left_r == CNT_W'(1)) ? S_TX_NEXT : S_WR_A;
      end
      S_TX_NEXT: begin
        if (!is_read_r || (pos_r < 3'd3)) begin
          if (pos_r < 3'd6) begin
            unique case (pos_r)
              3'd0:    tx_byte_nxt = hdr_addr_r;
              3'd1:    tx_byte_nxt = hdr_fc_r;
              3'd2:    tx_byte_nxt = is_read_r ? {wc_r[6:0], 1'b0} : ad_r[15:8];
              3'd3:    tx_byte_nxt = ad_r[7:0];
              3'd4:    tx_byte_nxt = wc_r[15:8];
              default: tx_byte_nxt = wc_r[7:0];
            endcase
            pos_nxt   = pos_r + 3'd1;
            state_nxt = S_TX_LOAD;
          end else begin
            state_nxt = S_CRC_LO;
          end
        end else if (phase_r) begin
          tx_byte_nxt = word_r[7:0];
          phase_nxt   = 1'b0;
          left_nxt    = left_r - CNT_W'(1);
          state_nxt   = S_TX_LOAD;
        end else begin
          state_nxt = (left_r == '0) ? S_CRC_LO : S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        word_nxt    = is_hold_r ? hold_rdata : inp_rdata;
        tx_byte_nxt = is_hold_r ? hold_rdata[15:8] : inp_rdata[15:8];
        phase_nxt   = 1'b1;
        cur_ad_nxt  = cur_ad_r + 16'd1;
        state_nxt   = S_TX_LOAD;
      end
      S_TX_LOAD: begin
        if (out_free && !crc_busy) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BYTE;
          out_byte_nxt  = tx_byte_r;
          out_last_nxt  = 1'b0;
          crc_ctl.load  = 1'b1;
          crc_ctl.data  = tx_byte_r;
          state_nxt     = S_TX_CRC;
        end
      end
      S_TX_CRC: begin
        if (!crc_busy) begin
          state_nxt = S_TX_NEXT;
        end
      end
      S_CRC_LO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BYTE;
          out_byte_nxt  = crc[7:0];
          out_last_nxt  = 1'b0;
          state_nxt     = S_CRC_HI;
        end
      end
      S_CRC_HI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_BYTE;
          out_byte_nxt  = crc[15:8];
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RESTART: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RESTART;
          out_byte_nxt  = 8'd0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      rx_len_r     <= '0;
      rx_ovf_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      slave_addr_r <= 8'd1;
      prot_limit_r <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rx_len_r    <= rx_len_nxt;
      rx_ovf_r    <= rx_ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLAVE_ADDR: slave_addr_r <= cfg_wdata;
          CFG_PROT_LIMIT: prot_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    eof_r      <= eof_nxt;
    hdr_addr_r <= hdr_addr_nxt;
    hdr_fc_r   <= hdr_fc_nxt;
    bc_r       <= bc_nxt;
    ad_r       <= ad_nxt;
    wc_r       <= wc_nxt;
    cur_ad_r   <= cur_ad_nxt;
    word_r     <= word_nxt;
    left_r     <= left_nxt;
    wr_idx_r   <= wr_idx_nxt;
    pos_r      <= pos_nxt;
    phase_r    <= phase_nxt;
    is_read_r  <= is_read_nxt;
    is_hold_r  <= is_hold_nxt;
    tx_byte_r  <= tx_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  mrtu_crc u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .crc  (crc),
    .busy (crc_busy)
  );

  mrtu_ram #(.WIDTH(16), .DEPTH(HOLDING_WORDS)) u_hold_ram (
    .clk  (clk),
    .we   (hold_we),
    .waddr(hold_waddr),
    .wdata(hold_wdata),
    .raddr(cur_ad_r[HA_W-1:0]),
    .rdata(hold_rdata)
  );

  mrtu_ram #(.WIDTH(16), .DEPTH(INPUT_WORDS)) u_inp_ram (
    .clk  (clk),
    .we   (inp_we),
    .waddr(inp_waddr),
    .wdata(inp_wdata),
    .raddr(cur_ad_r[IA_W-1:0]),
    .rdata(inp_rdata)
  );

  mrtu_ram #(.WIDTH(8), .DEPTH(RX_BYTES)) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_len_r[RXA_W-1:0]),
    .wdata(in_byte),
    .raddr(wr_idx_r),
    .rdata(rx_rdata)
  );

  a_no_ovf_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> !rx_ovf_r)
    else $error("overflowed frame reached the check step");

  a_restart_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_RESTART)) |-> ((out_byte_r == 8'd0) && out_last_r))
    else $error("restart word with data or not last");

  a_crc_settled: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CRC_LO) || (state_r == S_CRC_HI)) |-> !crc_busy)
    else $error("CRC sent while still shifting");

  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser == OP_FRAME) && (32'(rx_len_r) < RX_BYTES))
      |=> (rx_len_r == $past(rx_len_r) + LEN_W'(1)))
    else $error("frame length did not advance");

endmodule
`default_nettype wire

// ----- rtl/core/mrtu_ram.sv -----
`default_nettype none
module mrtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/mrtu_crc.sv -----
`default_nettype none
module mrtu_crc
  import mrtu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire crc_ctl_t    ctl,
  output logic      [15:0] crc,
  output logic             busy
);

  // Bit-serial CRC-16: a byte is folded in at load, then one bit per cycle.
  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] base;

  always_comb begin
    base    = ctl.init ? CRC_INIT : crc_r;
    crc_nxt = base;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      crc_nxt = base ^ {8'd0, ctl.data};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (cnt_r != 4'd0);

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
  import mrtu_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } resp_t;

  localparam int NO_ACCEPT_LIMIT = 20000;

  // Opcode and function code that the block does not serve.
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [7:0] FC_UNKNOWN = 8'd5;

  class modbus_scoreboard;
    logic [7:0]  slave_addr;
    logic [7:0]  prot_limit;
    logic [15:0] hold_mem[HOLDING_WORDS_DEF];
    logic [15:0] in_mem[INPUT_WORDS_DEF];
    logic [7:0]  rx_q[$];
    bit          rx_over;
    resp_t       want_q[$];
    int          errors;
    int          checked;

    function new();
      slave_addr = 8'd1;
      prot_limit = 8'd0;
      foreach (hold_mem[i]) hold_mem[i] = '0;
      foreach (in_mem[i]) in_mem[i] = '0;
      rx_over = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [15:0] crc16(logic [7:0] q[$], int n);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < n; i++) begin
        c = c ^ {8'd0, q[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void emit(logic [7:0] tx[$]);
      logic [15:0] c;
      c = crc16(tx, tx.size());
      tx.push_back(c[7:0]);
      tx.push_back(c[15:8]);
      foreach (tx[i]) want_q.push_back('{KIND_BYTE, tx[i], i == tx.size() - 1});
    endfunction

    function bit crc_good(int len);
      logic [15:0] c;
      c = crc16(rx_q, len - 2);
      return rx_q[len-2] == c[7:0] && rx_q[len-1] == c[15:8];
    endfunction

    function void serve_request();
      int len, fc, ad, wc, bc, lim;
      logic [7:0] tx[$];
      len = rx_q.size();
      if (len < 2 || rx_q[0] != slave_addr) return;
      fc = rx_q[1];
      if (fc == FC_READ_HOLD || fc == FC_READ_INPUT || fc == FC_WRITE_ONE) begin
        if (len != 8 || !crc_good(len)) return;
        ad = {rx_q[2], rx_q[3]};
        wc = {rx_q[4], rx_q[5]};
        if (fc == FC_WRITE_ONE) begin
          if (ad >= HOLDING_WORDS_DEF) return;
          if (ad > prot_limit) begin
            hold_mem[ad] = wc[15:0];
            tx = rx_q[0:5];
            emit(tx);
          end else begin
            want_q.push_back('{KIND_RESTART, 8'd0, 1'b1});
          end
          return;
        end
        if (wc == 0 || wc > MAX_READ_WORDS_DEF) return;
        lim = (fc == FC_READ_HOLD) ? HOLDING_WORDS_DEF : INPUT_WORDS_DEF;
        if (ad + wc > lim) return;
        tx = {rx_q[0], rx_q[1], 8'(wc * 2)};
        for (int i = 0; i < wc; i++) begin
          logic [15:0] w;
          w = (fc == FC_READ_HOLD) ? hold_mem[ad+i] : in_mem[ad+i];
          tx.push_back(w[15:8]);
          tx.push_back(w[7:0]);
        end
        emit(tx);
      end else if (fc == FC_WRITE_MANY) begin
        if (len < 9) return;
        bc = rx_q[6];
        if (len != 9 + bc || !crc_good(len)) return;
        ad = {rx_q[2], rx_q[3]};
        wc = {rx_q[4], rx_q[5]};
        if (wc == 0 || wc > MAX_WRITE_WORDS_DEF || bc != wc * 2) return;
        if (ad + wc > HOLDING_WORDS_DEF) return;
        for (int i = 0; i < wc; i++)
          if (ad + i > prot_limit) hold_mem[ad+i] = {rx_q[7+2*i], rx_q[8+2*i]};
        tx = rx_q[0:5];
        emit(tx);
      end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b, logic eof, logic [8:0] idx,
                             logic [15:0] val);
      if (op == OP_LOAD_IN) begin
        if (idx < INPUT_WORDS_DEF) in_mem[idx] = val;
      end else if (op == OP_LOAD_HOLD) begin
        if (idx < HOLDING_WORDS_DEF) hold_mem[idx] = val;
      end else if (op == OP_FRAME) begin
        if (rx_q.size() < RX_BYTES_DEF) rx_q.push_back(b);
        else rx_over = 1;
        if (eof) begin
          if (!rx_over) serve_request();
          rx_q = {};
          rx_over = 0;
        end
      end
    endfunction

    function void check_result(logic kind, logic [7:0] b, logic last);
      resp_t w;
      checked++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected word kind=%0b byte=%02h last=%0b", $time, kind, b, last);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (kind !== w.kind) begin
        $display("%0t: kind expected %0b actual %0b", $time, w.kind, kind);
        errors++;
      end
      if (b !== w.data) begin
        $display("%0t: byte expected %02h actual %02h", $time, w.data, b);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last expected %0b actual %0b", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;

  modbus_rtu_slave_register_engine DUT (.*);

  modbus_scoreboard sb = new();
  logic [7:0] frame_q[$];
  int burst_left = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int hold_cycles = 0;
  int idle_count = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready pattern is one of three modes, drawn anew when a counter runs out; a requested hold-off wins.
  initial begin
    int mode, cnt;
    out_tready = 0;
    mode = 0;
    cnt = 0;
    forever begin
      @(posedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(0, 2);
        cnt = 64;
      end
      cnt--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (mode == 0) begin
        out_tready <= 1'b1;
      end else if (mode == 1) begin
        out_tready <= $urandom_range(0, 1);
      end else begin
        out_tready <= ($urandom_range(0, 4) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > NO_ACCEPT_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, NO_ACCEPT_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called right after a rising edge; leaves in_tvalid high after acceptance.
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic eof, logic [8:0] idx,
                           logic [15:0] val);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, val, idx, b};
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, b, eof, idx, val);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_load(logic [1:0] op, logic [8:0] idx, logic [15:0] val);
    send_item(op, 8'($urandom), 1'($urandom), idx, val);
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_item(OP_FRAME, frame_q[i], i == frame_q.size() - 1, 9'($urandom), 16'($urandom));
    frames_sent++;
  endtask

  // flaw: 0 none, 1 bad CRC, 2 foreign address, 3 byte missing, 4 byte count mismatch.
  task automatic build_frame(int fc, int ad, int wc, int flaw);
    logic [15:0] c;
    int bc;
    frame_q = {};
    frame_q.push_back(flaw == 2 ? sb.slave_addr + 8'd1 : sb.slave_addr);
    frame_q.push_back(8'(fc));
    frame_q.push_back(8'(ad >> 8));
    frame_q.push_back(8'(ad));
    frame_q.push_back(8'(wc >> 8));
    frame_q.push_back(8'(wc));
    if (fc == FC_WRITE_MANY) begin
      bc = 2 * wc + (flaw == 4 ? 2 : 0);
      frame_q.push_back(8'(bc));
      repeat (bc) frame_q.push_back(8'($urandom));
    end
    c = sb.crc16(frame_q, frame_q.size());
    frame_q.push_back(flaw == 1 ? c[7:0] ^ 8'h01 : c[7:0]);
    frame_q.push_back(c[15:8]);
    if (flaw == 3) frame_q.delete(2);
  endtask

  task automatic frame(int fc, int ad, int wc, int flaw);
    build_frame(fc, ad, wc, flaw);
    send_frame();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // A rejected frame produces nothing; let its check finish.
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SLAVE_ADDR) sb.slave_addr = val;
    else sb.prot_limit = val;
  endtask

  task automatic random_item();
    int pick, fc, wc, ad;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 3))
        0: fc = FC_READ_HOLD;
        1: fc = FC_READ_INPUT;
        2: fc = FC_WRITE_ONE;
        default: fc = FC_WRITE_MANY;
      endcase
      if (fc == FC_WRITE_ONE) begin
        frame(fc, $urandom_range(0, 255), $urandom_range(0, 65535), 0);
      end else begin
        wc = ($urandom_range(0, 9) == 0) ?
             (fc == FC_WRITE_MANY ? MAX_WRITE_WORDS_DEF : MAX_READ_WORDS_DEF) :
             $urandom_range(1, 4);
        ad = $urandom_range(0, (fc == FC_READ_INPUT ? INPUT_WORDS_DEF : HOLDING_WORDS_DEF) - wc);
        frame(fc, ad, wc, 0);
      end
    end else if (pick < 75) begin
      send_load($urandom_range(0, 1) ? OP_LOAD_IN : OP_LOAD_HOLD, 9'($urandom), 16'($urandom));
    end else if (pick < 77) begin
      send_load(OP_UNUSED, 9'($urandom), 16'($urandom));
    end else if (pick < 96) begin
      fc = $urandom_range(0, 1) ? FC_WRITE_MANY : FC_READ_HOLD;
      frame(fc, $urandom_range(0, 520), $urandom_range(0, 31), $urandom_range(0, 4));
    end else if (pick < 98) begin
      frame_q = {sb.slave_addr};
      repeat ($urandom_range(63, 70)) frame_q.push_back(8'($urandom));
      send_frame();
    end else begin
      frame_q = {};
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      send_frame();
    end
  endtask

  task automatic random_phase(int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) random_item();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_FRAME;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SLAVE_ADDR;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(CFG_SLAVE_ADDR, 8'd1);
    cfg_write(CFG_PROT_LIMIT, 8'd10);

    // Directed part.
    send_item(OP_LOAD_HOLD, 8'h00, 1'b0, 9'd5, 16'hFFFF);
    send_item(OP_LOAD_HOLD, 8'hFF, 1'b0, 9'd300, 16'h1234);
    send_item(OP_LOAD_IN, 8'h55, 1'b1, 9'd511, 16'hA5A5);
    send_item(OP_UNUSED, 8'hAA, 1'b1, 9'h1FF, 16'h0000);
    frame(FC_READ_HOLD, 0, MAX_READ_WORDS_DEF, 0);
    frame(FC_READ_INPUT, INPUT_WORDS_DEF - MAX_READ_WORDS_DEF, MAX_READ_WORDS_DEF, 0);
    frame(FC_READ_INPUT, INPUT_WORDS_DEF - MAX_READ_WORDS_DEF + 1, MAX_READ_WORDS_DEF, 0);
    frame(FC_READ_HOLD, 0, MAX_READ_WORDS_DEF + 1, 0);
    frame(FC_READ_HOLD, 0, 0, 0);
    frame(FC_WRITE_ONE, 255, 16'hFFFF, 0);
    frame(FC_WRITE_ONE, 256, 16'h1111, 0);
    frame(FC_WRITE_ONE, 10, 16'h2222, 0);
    frame(FC_WRITE_ONE, 11, 16'h0000, 0);
    frame(FC_WRITE_MANY, 0, MAX_WRITE_WORDS_DEF, 0);
    frame(FC_WRITE_MANY, 254, 3, 0);
    frame(FC_WRITE_MANY, 20, 2, 4);
    frame(FC_READ_HOLD, 0, MAX_WRITE_WORDS_DEF, 0);
    frame(FC_READ_HOLD, 250, 6, 0);
    frame(FC_READ_HOLD, 0, 1, 1);
    frame(FC_READ_HOLD, 0, 1, 2);
    frame(FC_READ_INPUT, 0, 1, 3);
    frame(FC_UNKNOWN, 0, 1, 0);
    frame_q = {8'd1};
    send_frame();
    frame_q = {8'd1};
    repeat (64) frame_q.push_back(8'($urandom));
    send_frame();
    frame(FC_READ_HOLD, 250, 6, 0);

    drain();
    cfg_write(CFG_SLAVE_ADDR, 8'd255);
    cfg_write(CFG_PROT_LIMIT, 8'd255);
    random_phase(10);
    // Long receiver hold-off while requests keep coming.
    hold_cycles = 400;
    random_phase(15);
    drain();

    cfg_write(CFG_SLAVE_ADDR, 8'd0);
    cfg_write(CFG_PROT_LIMIT, 8'd0);
    random_phase(10);

    drain();
    cfg_write(CFG_SLAVE_ADDR, 8'($urandom));
    cfg_write(CFG_PROT_LIMIT, 8'($urandom));
    random_phase(10);

    drain();
    $display("Sent %0d input words in %0d frames over four register settings.",
             words_sent, frames_sent);
    $display("Checked %0d response words; %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
